/* sv/dfa_string_matcher_top_macros.svh */
`ifndef DFA_STRING_MATCHER_TOP_MACROS_SVH
`define DFA_STRING_MATCHER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsm assertion failed");

// next-cycle implication, disabled during reset
`define DSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsm assertion failed");

`endif

/* sv/dsm_pkg.sv */
`timescale 1ns / 1ps

package dsm_pkg;

  localparam int SLOTS       = 12;
  localparam int LETTER_W    = 5;
  localparam int STATE_W     = 4;
  localparam int POS_W       = 32;
  localparam int PAT_W       = SLOTS * LETTER_W;
  localparam int APB_DW      = 64;
  localparam int APB_AW      = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // register select on paddr[3]
  localparam logic REG_PATTERN_LETTERS = 1'b0;
  localparam logic REG_PATTERN_LENGTH  = 1'b1;

  typedef struct packed {
    logic               stale;
    logic [STATE_W-1:0] length;
  } cfg_t;

endpackage

/* sv/dsm_cfg.sv */
`timescale 1ns / 1ps

module dsm_cfg #(
  parameter int MAX_PATTERN = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dsm_pkg::APB_AW-1:0]          paddr,
  input  logic [dsm_pkg::APB_DW-1:0]          pwdata,
  output logic [dsm_pkg::APB_DW-1:0]          prdata,
  output dsm_pkg::cfg_t                       cfg,
  output logic [dsm_pkg::PAT_W-1:0]           pattern,
  output logic [MAX_PATTERN:0][MAX_PATTERN-1:0] border
);
  import dsm_pkg::*;

  logic [PAT_W-1:0]                  pattern_letters;
  logic [STATE_W-1:0]                pattern_length;
  logic                              stale;
  logic [MAX_PATTERN:0][MAX_PATTERN-1:0] border_next;
  logic                              wr;

  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_letters <= '0;
      pattern_length  <= STATE_W'(1);
      stale           <= 1'b1;
    end else begin
      stale <= wr && (paddr[3] == REG_PATTERN_LETTERS);
      if (wr) begin
        unique case (paddr[3])
          REG_PATTERN_LETTERS: begin
            pattern_letters <= pwdata[PAT_W-1:0];
          end
          REG_PATTERN_LENGTH: begin
            pattern_length <= pwdata[STATE_W-1:0];
          end
        endcase
      end
    end
  end

  // border[q][k-1]: first k-1 pattern letters end the first q pattern letters
  always_comb begin
    border_next = '0;
    for (int q = 0; q <= MAX_PATTERN; q++) begin
      for (int k = 1; k <= MAX_PATTERN && k <= q + 1; k++) begin
        border_next[q][k-1] = 1'b1;
        for (int j = 0; j < k - 1; j++) begin
          if (pattern_letters[LETTER_W*j +: LETTER_W] !=
              pattern_letters[LETTER_W*(q-k+1+j) +: LETTER_W])
            border_next[q][k-1] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    border <= border_next;
  end

  always_comb begin
    if (pattern_length == '0)
      cfg.length = STATE_W'(1);
    else if (pattern_length > STATE_W'(MAX_PATTERN))
      cfg.length = STATE_W'(MAX_PATTERN);
    else
      cfg.length = pattern_length;
    cfg.stale = stale;
  end

  assign pattern = pattern_letters;

  always_comb begin
    unique case (paddr[3])
      REG_PATTERN_LETTERS: prdata = {{(APB_DW-PAT_W){1'b0}}, pattern_letters};
      REG_PATTERN_LENGTH:  prdata = {{(APB_DW-STATE_W){1'b0}}, pattern_length};
    endcase
  end

endmodule

/* sv/dsm_core.sv */
`timescale 1ns / 1ps

module dsm_core #(
  parameter int MAX_PATTERN   = 12,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [dsm_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [dsm_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tuser,
  input  dsm_pkg::cfg_t                         cfg,
  input  logic [dsm_pkg::PAT_W-1:0]             pattern,
  input  logic [MAX_PATTERN:0][MAX_PATTERN-1:0] border
);
  import dsm_pkg::*;

  localparam int QW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN + 1) : 1;

  logic                  in_valid;
  logic [LETTER_W-1:0]   in_letter;
  logic [STATE_W-1:0]    prefix_state;
  logic [POS_W-1:0]      text_position;
  logic                  out_valid;
  logic                  out_found;
  logic [POS_W-1:0]      out_shift;
  logic [STATE_W-1:0]    out_prefix;

  logic                  move;
  logic [STATE_W-1:0]    q_cur;
  logic [STATE_W-1:0]    lim;
  logic [MAX_PATTERN-1:0] row;
  logic                  letter_ok;
  logic [STATE_W-1:0]    q_next;
  logic                  found;
  logic [POS_W-1:0]      shift;

  assign move     = in_valid & ~cfg.stale & (~out_valid | m_tready);
  assign s_tready = ~in_valid | move;

  always_comb begin
    q_cur     = (prefix_state > cfg.length) ? cfg.length : prefix_state;
    lim       = (q_cur < cfg.length) ? q_cur + STATE_W'(1) : cfg.length;
    row       = border[q_cur[QW-1:0]];
    letter_ok = {1'b0, in_letter} < (LETTER_W+1)'(ALPHABET_SIZE);
    q_next    = '0;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      if (row[k-1] && (STATE_W'(k) <= lim) && letter_ok &&
          (pattern[LETTER_W*(k-1) +: LETTER_W] == in_letter))
        q_next = STATE_W'(k);
    end
    found = (q_next == cfg.length);
    shift = found ? text_position - POS_W'(cfg.length) + POS_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      prefix_state  <= '0;
      text_position <= '0;
    end else begin
      if (s_tready)
        in_valid <= s_tvalid;
      if (move) begin
        prefix_state  <= q_next;
        text_position <= text_position + POS_W'(1);
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready)
      in_letter <= s_tdata[LETTER_W-1:0];
    if (move) begin
      out_found  <= found;
      out_shift  <= shift;
      out_prefix <= q_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = {{(OUT_TDATA_W-POS_W-STATE_W){1'b0}}, out_prefix, out_shift};

endmodule

/* sv/dfa_string_matcher_top.sv */
`timescale 1ns / 1ps
// An accepted input beat passes the input reg, then the result reg, to become its result beat.
// One letter per cycle unless stalled; the state update is a single registered transition.
// Stalls: automaton table reload after a pattern_letters write; m_tready low with a result held.
// Reset (rst, synchronous, active high): state, position and pipeline cleared,
// pattern_letters = 0, pattern_length = 1.
module dfa_string_matcher_top #(
  parameter int MAX_PATTERN   = 12,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dsm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [4:0] letter
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dsm_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] match_shift, [35:32] matched_prefix
  output logic                            m_tuser,   // [0] match_found
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsm_pkg::APB_AW-1:0]      paddr,
  input  logic [dsm_pkg::APB_DW-1:0]      pwdata,
  output logic [dsm_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import dsm_pkg::*;

  cfg_t                                  cfg;
  logic [PAT_W-1:0]                      pattern;
  logic [MAX_PATTERN:0][MAX_PATTERN-1:0] border;

  assign pready = 1'b1;

  dsm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .pattern (pattern),
    .border  (border)
  );

  dsm_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg      (cfg),
    .pattern  (pattern),
    .border   (border)
  );

endmodule

/* sv/dsm_checker.sv */
`timescale 1ns / 1ps
`include "dfa_string_matcher_top_macros.svh"

module dsm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dsm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import dsm_pkg::*;

  `DSM_ASSERT_NOW(a_prefix_range, clk, rst, m_tvalid, m_tdata[35:32] <= STATE_W'(SLOTS))
  `DSM_ASSERT_NOW(a_match_nonzero, clk, rst, m_tvalid && m_tuser, m_tdata[35:32] != '0)
  `DSM_ASSERT_NOW(a_shift_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[31:0] == '0)
  `DSM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind dfa_string_matcher_top dsm_checker u_dsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
